// ----- src/cph_pkg.sv -----
// Shared types, constants and the arctangent table for the phase-to-hue block.
// No dependencies.
package cph_pkg;

    localparam int SAMPLE_WIDTH_DEF  = 24;
    localparam int ANGLE_STEPS_DEF   = 18;
    localparam int FRACTION_BITS_DEF = 8;

    localparam int TABLE_LEN = 24;
    localparam int PRESCALE  = 24;
    localparam int HUE_W     = 16;
    localparam int HUE_MAX_W = 8;
    localparam int ADDR_W    = 3;

    localparam logic [HUE_MAX_W-1:0] HUE_MAX_RESET = 8'd255;
    localparam logic                 REG_HUE_MAX   = 1'b0;

    localparam logic [31:0] ZERO_TURN          = 32'h0000_0000;
    localparam logic [31:0] QUARTER_TURN       = 32'h4000_0000;
    localparam logic [31:0] HALF_TURN          = 32'h8000_0000;
    localparam logic [31:0] THREE_QUARTER_TURN = 32'hC000_0000;

    // atan(2^-i) as a binary angle, 2^32 is one turn
    localparam logic [31:0] ATAN_TURNS [TABLE_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic valid;
        logic on_axis;
        logic neg_imag;
    } t_ctrl;

endpackage

// ----- src/cph_cordic_stage.sv -----
// One registered vectoring step of the CORDIC pipeline.
// Depends on cph_pkg.
module cph_cordic_stage import cph_pkg::*; #(
    parameter int XW   = 51,
    parameter int STEP = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl                i_ctrl,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic        [31:0]   i_z,
    output t_ctrl                o_ctrl,
    output logic signed [XW-1:0] o_x,
    output logic signed [XW-1:0] o_y,
    output logic        [31:0]   o_z
);

    t_ctrl                r_ctrl;
    logic signed [XW-1:0] r_x, r_y, n_x, n_y;
    logic        [31:0]   r_z, n_z;
    logic signed [XW-1:0] dx, dy;

    assign dx = i_y >>> STEP;
    assign dy = i_x >>> STEP;

    always_comb begin
        if (!i_y[XW-1]) begin
            n_x = i_x + dx;
            n_y = i_y - dy;
            n_z = i_z + ATAN_TURNS[STEP];
        end else begin
            n_x = i_x - dx;
            n_y = i_y + dy;
            n_z = i_z - ATAN_TURNS[STEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl <= '0;
        end else begin
            r_ctrl <= i_ctrl;
        end
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_ctrl = r_ctrl;
    assign o_x    = r_x;
    assign o_y    = r_y;
    assign o_z    = r_z;

endmodule

// ----- src/complex_phase_to_hue.sv -----
// Top level: complex sample to hue, CORDIC phase pipeline and hue scaling.
// Depends on cph_pkg and cph_cordic_stage.
//
//  channel   handshake                 payload
//  input     start / busy              i_real_part, i_imag_part
//  result    o_hue_valid (strobe)      o_hue_fixed
//  config    APB psel/penable/pready   paddr, pwdata, prdata (hue_max at 0x0)
//
// One beat per cycle. Prescale loads at the accepting edge, then one CORDIC step per stage
// (ANGLE_STEPS stages, capped at the table length), multiply, round: the strobe rises
// together with the rounded result.
// busy is never raised; the pipeline has no back-pressure to absorb.
// Synchronous reset clears the valid bits and restores hue_max to 255.
module complex_phase_to_hue import cph_pkg::*; #(
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int ANGLE_STEPS   = ANGLE_STEPS_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [SAMPLE_WIDTH-1:0] i_real_part,
    input  logic signed [SAMPLE_WIDTH-1:0] i_imag_part,
    output logic                           o_hue_valid,
    output logic        [HUE_W-1:0]        o_hue_fixed,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic        [ADDR_W-1:0]       paddr,
    input  logic        [31:0]             pwdata,
    output logic        [31:0]             prdata,
    output logic                           pready
);

    localparam int STEPS = (ANGLE_STEPS > TABLE_LEN) ? TABLE_LEN : ANGLE_STEPS;
    localparam int XW    = SAMPLE_WIDTH + PRESCALE + 3;
    localparam int LAT   = STEPS + 3;
    localparam logic [63:0] ROUND_HALF = 64'h0000_0000_8000_0000;

    // configuration
    logic [HUE_MAX_W-1:0] r_hue_max;
    logic                 cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_HUE_MAX);
    assign prdata = (paddr[2] == REG_HUE_MAX) ? {24'd0, r_hue_max} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hue_max <= HUE_MAX_RESET;
        end else if (cfg_wr) begin
            r_hue_max <= pwdata[HUE_MAX_W-1:0];
        end
    end

    assign busy = 1'b0;

    // input stage: fold into right half-plane and prescale
    logic signed [XW-1:0] re_ext, im_ext, n_x0, n_y0;
    logic        [31:0]   n_z0;
    t_ctrl                n_ctrl0;

    t_ctrl                s_ctrl [0:STEPS];
    logic signed [XW-1:0] s_x    [0:STEPS];
    logic signed [XW-1:0] s_y    [0:STEPS];
    logic        [31:0]   s_z    [0:STEPS];

    assign re_ext = {{(XW-SAMPLE_WIDTH){i_real_part[SAMPLE_WIDTH-1]}}, i_real_part};
    assign im_ext = {{(XW-SAMPLE_WIDTH){i_imag_part[SAMPLE_WIDTH-1]}}, i_imag_part};

    always_comb begin
        if (re_ext < 0) begin
            n_x0 = (-re_ext) <<< PRESCALE;
            n_y0 = (-im_ext) <<< PRESCALE;
            n_z0 = HALF_TURN;
        end else begin
            n_x0 = re_ext <<< PRESCALE;
            n_y0 = im_ext <<< PRESCALE;
            n_z0 = ZERO_TURN;
        end
        n_ctrl0.valid    = start && !busy;
        n_ctrl0.on_axis  = (i_real_part == '0);
        n_ctrl0.neg_imag = i_imag_part[SAMPLE_WIDTH-1];
    end

    t_ctrl                r_ctrl0;
    logic signed [XW-1:0] r_x0, r_y0;
    logic        [31:0]   r_z0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl0 <= '0;
        end else begin
            r_ctrl0 <= n_ctrl0;
        end
        r_x0 <= n_x0;
        r_y0 <= n_y0;
        r_z0 <= n_z0;
    end

    assign s_ctrl[0] = r_ctrl0;
    assign s_x[0]    = r_x0;
    assign s_y[0]    = r_y0;
    assign s_z[0]    = r_z0;

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        cph_cordic_stage #(
            .XW   (XW),
            .STEP (g)
        ) u_stage (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctrl (s_ctrl[g]),
            .i_x    (s_x[g]),
            .i_y    (s_y[g]),
            .i_z    (s_z[g]),
            .o_ctrl (s_ctrl[g+1]),
            .o_x    (s_x[g+1]),
            .o_y    (s_y[g+1]),
            .o_z    (s_z[g+1])
        );
    end

    // scale by hue_max
    logic [31:0] z_fin;
    logic [39:0] r_prod;
    logic        r_mul_valid;

    always_comb begin
        if (s_ctrl[STEPS].on_axis) begin
            z_fin = s_ctrl[STEPS].neg_imag ? THREE_QUARTER_TURN : QUARTER_TURN;
        end else begin
            z_fin = s_z[STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_valid <= 1'b0;
        end else begin
            r_mul_valid <= s_ctrl[STEPS].valid;
        end
        r_prod <= {8'd0, z_fin} * {32'd0, r_hue_max};
    end

    // round to nearest, ties up
    logic [63:0]      n_round;
    logic [HUE_W-1:0] r_hue;
    logic             r_out_valid;

    assign n_round = ({24'd0, r_prod} << FRACTION_BITS) + ROUND_HALF;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_mul_valid;
        end
        r_hue <= n_round[47:32];
    end

    assign o_hue_valid = r_out_valid;
    assign o_hue_fixed = r_hue;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_hue_valid)
        else $error("accepted beat did not produce a result on time");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hue_valid |-> $past(r_mul_valid))
        else $error("result strobe without a beat behind it");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_hue_valid)
        else $error("result strobe straight after reset");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hue_valid && FRACTION_BITS == 8) |-> (o_hue_fixed <= 16'hFF00))
        else $error("hue beyond one full turn");

endmodule
